// ----- design/segregated_fit_allocator_top_assert.svh -----
`ifndef SEGREGATED_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define SEGREGATED_FIT_ALLOCATOR_TOP_ASSERT_SVH
// assertion helpers
`define SFA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- design/sfa_pkg.sv -----
package sfa_pkg;
	localparam int FREE_ENTRIES = 64;
	localparam int ADDR_BITS = 32;
	localparam int IDX_W = $clog2(FREE_ENTRIES);
	localparam int AW = ADDR_BITS + 1;

	localparam logic [1:0] ST_REUSE = 2'd0;
	localparam logic [1:0] ST_CARVE = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;
	localparam logic [1:0] ST_EXHAUST = 2'd3;

	localparam logic [1:0] REG_POOL = 2'd0;
	localparam logic [1:0] REG_CLASS = 2'd1;
	localparam logic [1:0] REG_TRAV = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [15:0] size;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [31:0] address_res;
		logic [1:0]  status;
		logic        dropped;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request, start class division
		logic scan_clr;  // clear best tracking
		logic scan_step; // evaluate entry at scan index
		logic decide;    // pick reuse or carve, queue table add
		logic add_step;  // finish table add, build result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic scan_last;
		logic is_free;
	} sts_t;
endpackage

// ----- design/segregated_fit_allocator_top.sv -----
// Segregated free-list allocator; an allocate picks the lowest fitting class.
// Request channel: drive req (mode, size, address) with start; the request
// transfers on a clock edge where start is high and busy is low.
// Result channel: res (address_res, status, dropped) is valid for exactly one
// cycle while done is high; the receiver cannot stall it.
// Config: cfg_we with cfg_idx 0 initial pool length, 1 class width, 2 number
// of higher classes a search may visit; write only while idle. Other indexes
// are ignored.
// Each request runs two class divisions in the shared bit-serial divider; an
// allocate also scans the 64 free table entries through the registered-read
// entry memory.
// One request is in flight at a time; busy drops in the cycle done is high,
// so the next request can transfer at the edge that takes the result.
// Reset clears valid bits, pointers, config registers and the result to their
// defaults; the entry memory and the search registers are not cleared.
module segregated_fit_allocator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sfa_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [15:0]   cfg_data,
	output logic          done,
	output sfa_pkg::res_t res
);
	import sfa_pkg::*;
	cmd_t cmd;
	sts_t sts;
	sfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd), .done(done)
	);
	sfa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(req),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .res(res)
	);
endmodule

// ----- design/sfa_ram.sv -----
module sfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/sfa_div.sv -----
// restoring divider, one quotient bit per cycle
module sfa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quot
);
	import sfa_pkg::*;
	logic [31:0] q_q;
	logic [15:0] rem_q;
	logic [15:0] d_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [16:0] trial;
	always_comb trial = {rem_q, q_q[31]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) run_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			rem_q <= '0;
			d_q <= (divisor == 16'd0) ? 16'd1 : divisor;
		end else if (run_q) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= 16'(trial - {1'b0, d_q});
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
	assign done = !run_q && !go;
	assign quot = q_q;
endmodule

// ----- design/sfa_datapath.sv -----
module sfa_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  sfa_pkg::cmd_t cmd,
	output sfa_pkg::sts_t sts,
	input  sfa_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [15:0]   cfg_data,
	output sfa_pkg::res_t res
);
	import sfa_pkg::*;

	logic [15:0] class_width_q;
	logic [7:0]  max_trav_q;
	logic [AW-1:0] pool_base_q, cur_size_q, bump_q;
	logic [31:0] stamp_q;
	logic [FREE_ENTRIES-1:0] valid_q;
	req_t req_q;

	// entry memory: start, length, class, age
	localparam int EW = 32 + 32 + 32 + 32;
	logic          we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	sfa_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [31:0] e_start;
	logic [31:0] e_len, e_cls;
	logic [31:0] e_age;
	assign {e_start, e_len, e_cls, e_age} = rdata;

	// class division shared by request and table add
	logic        div_go, div_done;
	logic [31:0] div_in, div_quot;
	sfa_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_in),
		.divisor(class_width_q), .done(div_done), .quot(div_quot)
	);

	logic [IDX_W:0] scan_q;
	logic [IDX_W-1:0] idx_s1;
	logic        vld_s1;
	logic [31:0] pos_q;
	logic        found_q;
	logic [IDX_W-1:0] best_q;
	logic [31:0] best_cls_q, best_len_q;
	logic [31:0] best_gap_q, best_start_q;

	// pending table add
	logic        add_q;
	logic [31:0] add_start_q;
	logic [31:0] add_len_q;
	logic [1:0]  status_q;
	logic [31:0] resaddr_q;

	logic [IDX_W-1:0] free_slot;
	logic        any_free;
	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign raddr = scan_q[IDX_W-1:0];
	assign sts.scan_last = vld_s1 && (idx_s1 == IDX_W'(FREE_ENTRIES - 1));
	assign sts.div_done = div_done;
	assign sts.is_free = req_q.mode;

	logic [31:0] age_gap;
	logic        cand;
	logic [31:0] cdiff;
	always_comb begin
		age_gap = stamp_q - e_age;
		cdiff = e_cls - pos_q;
		cand = vld_s1 && valid_q[idx_s1] && (e_len >= {16'd0, req_q.size}) &&
			(e_cls >= pos_q) && (cdiff <= {24'd0, max_trav_q});
	end

	// carve decision
	logic          grow, full, exhaust;
	logic [AW-1:0] new_size, new_base, limit, sz;
	always_comb begin
		sz = AW'(req_q.size);
		limit = AW'(1) << ADDR_BITS;
		grow = sz > cur_size_q;
		full = (bump_q + sz) > cur_size_q;
		new_size = grow ? cur_size_q + sz : cur_size_q;
		new_base = pool_base_q + cur_size_q;
		exhaust = (new_base > limit) || (new_size > limit - new_base);
	end

	logic        add_d;
	logic [31:0] add_start_d;
	logic [31:0] add_len_d;
	logic [1:0]  status_d;
	logic [31:0] resaddr_d;
	always_comb begin
		add_d = 1'b0;
		add_start_d = req_q.address;
		add_len_d = {16'd0, req_q.size};
		status_d = ST_FREED;
		resaddr_d = '0;
		if (req_q.mode) begin
			add_d = req_q.size != 16'd0;
		end else if (found_q) begin
			status_d = ST_REUSE;
			resaddr_d = best_start_q;
			add_start_d = best_start_q + {16'd0, req_q.size};
			add_len_d = best_len_q - {16'd0, req_q.size};
			add_d = best_len_q > {16'd0, req_q.size};
			if (req_q.size == 16'd0) begin
				add_start_d = best_start_q;
				add_len_d = best_len_q;
			end
		end else if ((grow || full) && exhaust) begin
			status_d = ST_EXHAUST;
		end else if (grow || full) begin
			status_d = ST_CARVE;
			resaddr_d = new_base[31:0];
			add_start_d = 32'(pool_base_q + bump_q);
			add_len_d = 32'(cur_size_q - bump_q);
			add_d = add_len_d != 32'd0;
		end else begin
			status_d = ST_CARVE;
			resaddr_d = 32'(pool_base_q + bump_q);
		end
	end

	// division requested at load (request class) and at decide (entry class)
	always_comb begin
		div_go = 1'b0;
		div_in = {16'd0, req.size};
		if (cmd.load) begin
			div_go = 1'b1;
			div_in = {16'd0, req.size};
		end else if (cmd.decide) begin
			div_go = 1'b1;
			div_in = add_len_d;
		end
	end

	logic slot_ok;
	assign slot_ok = any_free || (!req_q.mode && found_q);
	logic [IDX_W-1:0] tgt;
	assign tgt = any_free ? free_slot : best_q;

	always_comb begin
		we = cmd.add_step && add_q && slot_ok;
		waddr = tgt;
		wdata = {add_start_q, add_len_q, div_quot, stamp_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_width_q <= 16'd16;
			max_trav_q <= 8'd4;
			pool_base_q <= '0;
			cur_size_q <= AW'(1024);
			bump_q <= '0;
			stamp_q <= '0;
			valid_q <= '0;
			scan_q <= '0;
			vld_s1 <= 1'b0;
			res <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_POOL: begin
						if (pool_base_q == '0 && bump_q == '0) cur_size_q <= AW'(cfg_data);
					end
					REG_CLASS: class_width_q <= cfg_data;
					REG_TRAV: max_trav_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			vld_s1 <= cmd.scan_step && !scan_q[IDX_W];
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_step && !scan_q[IDX_W]) scan_q <= scan_q + {{IDX_W{1'b0}}, 1'b1};
			if (cmd.decide && !req_q.mode) begin
				if (found_q) valid_q[best_q] <= 1'b0;
				else if (status_d == ST_CARVE) begin
					if (grow || full) begin
						pool_base_q <= new_base;
						cur_size_q <= new_size;
						bump_q <= sz;
					end else bump_q <= bump_q + sz;
				end
			end
			if (we) begin
				valid_q[tgt] <= 1'b1;
				stamp_q <= stamp_q + 32'd1;
			end
			if (cmd.add_step)
				res <= '{address_res: resaddr_q, status: status_q,
					dropped: add_q && !slot_ok};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (div_done && cmd.scan_clr) pos_q <= div_quot;
		if (cmd.scan_clr) found_q <= 1'b0;
		else if (cand && (!found_q || e_cls < best_cls_q ||
				(e_cls == best_cls_q && age_gap < best_gap_q))) begin
			found_q <= 1'b1;
			best_q <= idx_s1;
			best_cls_q <= e_cls;
			best_gap_q <= age_gap;
			best_len_q <= e_len;
			best_start_q <= e_start;
		end
		if (cmd.scan_step) idx_s1 <= raddr;
		if (cmd.decide) begin
			add_q <= add_d;
			add_start_q <= add_start_d;
			add_len_q <= add_len_d;
			status_q <= status_d;
			resaddr_q <= resaddr_d;
		end
	end
endmodule

// ----- design/sfa_ctrl.sv -----
module sfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sfa_pkg::sts_t sts,
	output sfa_pkg::cmd_t cmd,
	output logic          done
);
	import sfa_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_ADIV = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	logic [2:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.load = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: if (sts.div_done) begin
				cmd.scan_clr = 1'b1;
				state_d = sts.is_free ? S_DEC : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d = S_ADIV;
			end
			S_ADIV: if (sts.div_done) state_d = S_OUT;
			S_OUT: begin
				cmd.add_step = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.add_step;
		end
	end
	assign busy = state_q != S_IDLE;
	assign done = done_q;
endmodule

// ----- design/sfa_checker.sv -----
`include "segregated_fit_allocator_top_assert.svh"
module sfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input sfa_pkg::res_t res
);
	import sfa_pkg::*;
	`SFA_ASSERT_NEXT(accept_busy, start && !busy, busy)
	`SFA_ASSERT_NEXT(done_one, done, !done)
	`SFA_ASSERT_IMPL(done_idle, done, !busy)
	`SFA_ASSERT_IMPL(freed_zero, done && res.status == ST_FREED, res.address_res == 32'd0)
endmodule

bind segregated_fit_allocator_top sfa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .res(res)
);

// ----- verif/segregated_fit_allocator_top_tb.sv -----
module segregated_fit_allocator_top_tb;
	import sfa_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	logic        done;
	res_t        res;

	segregated_fit_allocator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#80000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// predictor state
	logic [63:0] fl_start [FREE_ENTRIES];
	logic [63:0] fl_len [FREE_ENTRIES];
	logic [63:0] fl_cls [FREE_ENTRIES];
	logic [31:0] fl_age [FREE_ENTRIES];
	logic        fl_vld [FREE_ENTRIES];
	logic [31:0] stamp;
	logic [63:0] p_base, p_size, bump;
	logic [15:0] r_class;
	logic [7:0]  r_trav;

	res_t expected_q [$];
	int   errors = 0;
	int   idle_pct = 0;
	// rows with a fixed expected result
	logic row_fixed [$];
	res_t row_res [$];

	function automatic logic [63:0] class_of(logic [63:0] len);
		logic [63:0] w;
		w = (r_class == 0) ? 64'd1 : {48'd0, r_class};
		return len / w;
	endfunction

	function automatic logic table_add(logic [63:0] st, logic [63:0] len);
		if (len == 0) return 1'b0;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (!fl_vld[i]) begin
				fl_vld[i] = 1'b1;
				fl_start[i] = st;
				fl_len[i] = len;
				fl_cls[i] = class_of(len);
				fl_age[i] = stamp;
				stamp++;
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic model_reset();
		for (int i = 0; i < FREE_ENTRIES; i++) fl_vld[i] = 1'b0;
		stamp = 0;
		r_class = 16'd16;
		r_trav = 8'd4;
		p_base = 0;
		p_size = 1024;
		bump = 0;
	endtask

	function automatic res_t predict_alloc(req_t r);
		res_t o;
		logic [63:0] sz, pos, bcls, lim, nsize, nbase, bst, blen;
		logic [31:0] bgap, gap;
		int best;
		logic grow, full;
		o = '0;
		sz = {48'd0, r.size};
		if (r.mode) begin
			o.dropped = table_add({32'd0, r.address}, sz);
			o.status = ST_FREED;
			return o;
		end
		pos = class_of(sz);
		best = -1;
		bcls = 0;
		bgap = 0;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (!fl_vld[i] || fl_len[i] < sz) continue;
			if (fl_cls[i] < pos || fl_cls[i] - pos > {56'd0, r_trav}) continue;
			gap = stamp - fl_age[i];
			if (best < 0 || fl_cls[i] < bcls || (fl_cls[i] == bcls && gap < bgap)) begin
				best = i;
				bcls = fl_cls[i];
				bgap = gap;
			end
		end
		if (best >= 0) begin
			// the remainder may land in the slot just freed
			bst = fl_start[best];
			blen = fl_len[best];
			fl_vld[best] = 1'b0;
			if (blen > sz)
				o.dropped = table_add(bst + sz, blen - sz);
			o.address_res = bst[31:0];
			o.status = ST_REUSE;
			return o;
		end
		lim = 64'd1 << ADDR_BITS;
		grow = sz > p_size;
		full = bump + sz > p_size;
		o.status = ST_CARVE;
		if (grow || full) begin
			nsize = grow ? p_size + sz : p_size;
			nbase = p_base + p_size;
			if (nbase > lim || nsize > lim - nbase) begin
				o.status = ST_EXHAUST;
			end else begin
				o.dropped = table_add(p_base + bump, p_size - bump);
				p_base = nbase;
				p_size = nsize;
				bump = 0;
			end
		end
		if (o.status == ST_CARVE) begin
			o.address_res = p_base[31:0] + bump[31:0];
			bump += sz;
		end
		return o;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL) begin
			if (p_base == 0 && bump == 0) p_size = {48'd0, val};
		end else if (idx == REG_CLASS) begin
			r_class = val;
		end else if (idx == REG_TRAV) begin
			r_trav = val[7:0];
		end
	endtask

	// one transfer; start stays high across back-to-back items
	task automatic send(req_t r, logic fixed, res_t fres);
		res_t p;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = predict_alloc(r);
		expected_q.push_back(fixed ? fres : p);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 1'b0;
		while (expected_q.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		if (expected_q.size() != 0) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		repeat (200) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result %h", res);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (res.address_res !== e.address_res) begin
					$error("address_res exp %h got %h", e.address_res, res.address_res);
					errors++;
				end
				if (res.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res.status);
					errors++;
				end
				if (res.dropped !== e.dropped) begin
					$error("dropped exp %0d got %0d", e.dropped, res.dropped);
					errors++;
				end
			end
		end
	end

	function automatic req_t mk(logic m, logic [15:0] s, logic [31:0] a);
		req_t r;
		r.mode = m;
		r.size = s;
		r.address = a;
		return r;
	endfunction

	function automatic res_t rr(logic [31:0] a, logic [1:0] s, logic d);
		res_t o;
		o.address_res = a;
		o.status = s;
		o.dropped = d;
		return o;
	endfunction

	function automatic req_t rand_req(int kind);
		req_t r;
		r.mode = $urandom_range(99) < 45;
		case ($urandom_range(9))
			0: r.size = 16'd0;
			1: r.size = 16'hFFFF;
			2, 3: r.size = 16'($urandom);
			default: r.size = 16'($urandom_range(kind ? 200 : 64));
		endcase
		if ($urandom_range(3) == 0) r.address = $urandom;
		else r.address = $urandom_range(65535) << $urandom_range(16);
		return r;
	endfunction

	req_t dir_req [$];

	initial begin
		model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_req = '{mk(1'b0, 16'd10, 32'd0), mk(1'b0, 16'd0, 32'd0),
			mk(1'b1, 16'd0, 32'h1234), mk(1'b1, 16'd20, 32'hFFFFFFFF),
			mk(1'b0, 16'd20, 32'd0), mk(1'b1, 16'd40, 32'h100),
			mk(1'b0, 16'd8, 32'd0), mk(1'b0, 16'd0, 32'd0), mk(1'b0, 16'd2000, 32'd0),
			mk(1'b0, 16'hFFFF, 32'd0), mk(1'b1, 16'hFFFF, 32'h0), mk(1'b0, 16'd1, 32'd0),
			mk(1'b0, 16'd1014, 32'd0), mk(1'b1, 16'd5, 32'hAAAA5555),
			mk(1'b0, 16'd3, 32'd0)};
		row_fixed = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
			1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
		row_res = '{rr(32'd0, ST_CARVE, 1'b0), rr(32'd10, ST_CARVE, 1'b0),
			rr(32'd0, ST_FREED, 1'b0), rr(32'd0, ST_FREED, 1'b0),
			rr(32'hFFFFFFFF, ST_REUSE, 1'b0), rr(32'd0, ST_FREED, 1'b0),
			rr(32'h100, ST_REUSE, 1'b0), '0, '0, '0, rr(32'd0, ST_FREED, 1'b0), '0, '0,
			rr(32'd0, ST_FREED, 1'b0), '0};
		foreach (dir_req[i]) send(dir_req[i], row_fixed[i], row_res[i]);
		drain();

		// fill the table so drops show up
		for (int i = 0; i < FREE_ENTRIES + 4; i++)
			send(mk(1'b1, 16'd3 + i[15:0], $urandom), 1'b0, '0);
		send(mk(1'b0, 16'd2, 32'd0), 1'b0, '0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph < 2) ? 20 : (ph < 4) ? 47 : 0;
			case (ph)
				0: begin write_reg(REG_CLASS, 16'd1); write_reg(REG_TRAV, 16'd0); end
				1: begin write_reg(REG_CLASS, 16'hFFFF); write_reg(REG_TRAV, 16'd255); end
				2: begin write_reg(REG_CLASS, 16'd0); write_reg(REG_TRAV, 16'd2); end
				3: begin
					write_reg(REG_CLASS, 16'($urandom_range(1, 64)));
					write_reg(REG_TRAV, 16'($urandom));
				end
				4: begin write_reg(REG_POOL, 16'hFFFF); write_reg(REG_CLASS, 16'd8); end
				default: begin write_reg(REG_POOL, 16'd1); write_reg(REG_TRAV, 16'd1); end
			endcase
			write_reg(REG_POOL, (ph == 2) ? 16'd1 : 16'($urandom));
			write_reg(2'd3, 16'($urandom));
			for (int k = 0; k < 110; k++) send(rand_req(ph & 1), 1'b0, '0);
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
